// File: rtl/rfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Register file with bypass: shared definitions
// Types, field widths and register encodings used by the register file and
// its storage arrays.
// ----------------------------------------------------------------------------
package rfb_pkg;

	localparam int IDX_W = 5;
	localparam int DATA_W = 32;
	localparam int CNT_W = 7;

	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_SLOTS = 4;

	localparam int BIND_VLD_BIT = 10;
	localparam int BIND_SPC_LSB = 5;
	localparam int BIND_GEN_LSB = 0;

	localparam int PORT_A = 0;
	localparam int PORT_B = 1;
	localparam int PORT_C = 2;
	localparam int PORT_D = 3;
	localparam int PORT_DEST = 4;
	localparam int PORT_PAIR_A = 5;
	localparam int PORT_PAIR_B = 6;
	localparam int PORT_BIND = 7;
	localparam int NUM_GPORTS = 8;

	localparam int RES_SPECIAL = 7;
	localparam int NUM_RES = 8;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CFG_W-1:0] bind_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		data_t data;
	} wr_req_t;

	typedef struct packed {
		logic valid;
		logic special;
		idx_t idx;
		data_t data;
	} cur_wr_t;

endpackage
`default_nettype wire

// File: rtl/rfb_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Register file with bypass: storage array
// One write port and one registered read port. Per-entry valid bits are
// cleared by reset, so an entry that was never written reads as zero.
// ----------------------------------------------------------------------------
module rfb_mem #(
	parameter int DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rfb_pkg::wr_req_t wr,
	input  logic            rd_en,
	input  rfb_pkg::idx_t   rd_addr,
	output rfb_pkg::data_t  rd_data
);
	import rfb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	data_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	data_t rd_q;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;

	assign wa = wr.addr[AW-1:0];
	assign ra = rd_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wa] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= vld_q[ra] ? mem[ra] : '0;
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

// File: rtl/register_file_with_bypass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Register file with bypass
// Each request carries an optional write and reads seven general ports and
// one special port. A request is taken every cycle while the result side
// keeps up. The array reads are registered together with the request in
// stage one when it is accepted, and the bypass logic feeds the stage-two
// result register when the pipeline advances. Each general read port has
// its own copy of the general array, so all general reads proceed in
// parallel. A read sees the write of its own request first, then every
// earlier write. Reset clears both arrays at once through per-entry valid
// bits, so no clearing pass is needed. A special register bound through a
// binding slot reads its bound general register, the lowest slot winning.
// Indices not below an array's count read zero.
// ----------------------------------------------------------------------------
module register_file_with_bypass #(
	parameter int GENERAL_COUNT = 32,
	parameter int SPECIAL_COUNT = 32,
	parameter int BINDING_SLOTS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            write_enable,
	input  logic                            write_special,
	input  rfb_pkg::idx_t                   write_index,
	input  rfb_pkg::data_t                  write_value,
	input  rfb_pkg::idx_t                   read_index_a,
	input  rfb_pkg::idx_t                   read_index_b,
	input  rfb_pkg::idx_t                   read_index_c,
	input  rfb_pkg::idx_t                   read_index_d,
	input  rfb_pkg::idx_t                   dest_index,
	input  logic                            pair_a,
	input  logic                            pair_b,
	input  rfb_pkg::idx_t                   special_index,

	output logic                            out_valid,
	input  logic                            out_stall,
	output rfb_pkg::data_t                  value_a,
	output rfb_pkg::data_t                  value_b,
	output rfb_pkg::data_t                  value_c,
	output rfb_pkg::data_t                  value_d,
	output rfb_pkg::data_t                  dest_value,
	output rfb_pkg::data_t                  pair_value_a,
	output rfb_pkg::data_t                  pair_value_b,
	output rfb_pkg::data_t                  special_value,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  rfb_pkg::bind_t                  cfg_data
);
	import rfb_pkg::*;

	localparam int GEN_DEPTH = (GENERAL_COUNT < 32) ? GENERAL_COUNT : 32;
	localparam int SPC_DEPTH = (SPECIAL_COUNT < 32) ? SPECIAL_COUNT : 32;
	localparam cnt_t GEN_LIM = CNT_W'(GEN_DEPTH);
	localparam cnt_t SPC_LIM = CNT_W'(SPC_DEPTH);
	localparam cnt_t GEN_WRAP = CNT_W'(GENERAL_COUNT);

	bind_t binding_q [BINDING_SLOTS];

	logic accept;
	logic adv;

	cur_wr_t cur_d;
	idx_t gaddr_d [NUM_GPORTS];
	logic [NUM_GPORTS-1:0] gok_d;
	logic bind_hit_d;
	idx_t bind_idx_d;
	logic sok_d;
	cnt_t na;
	cnt_t nb;

	wr_req_t gen_wr;
	wr_req_t spc_wr;
	data_t gdata [NUM_GPORTS];
	data_t sdata;

	logic v_s1;
	cur_wr_t cur_s1;
	idx_t gaddr_s1 [NUM_GPORTS];
	logic [NUM_GPORTS-1:0] gok_s1;
	logic bind_hit_s1;
	idx_t saddr_s1;
	logic sok_s1;

	data_t gval [NUM_GPORTS];
	data_t sval;
	data_t res_d [NUM_RES];

	logic v_s2;
	data_t res_s2 [NUM_RES];

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < BINDING_SLOTS; s++) begin
				binding_q[s] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int s = 0; s < BINDING_SLOTS; s++) begin
				if (cfg_index == CFG_IDX_W'(s)) begin
					binding_q[s] <= cfg_data;
				end
			end
		end
	end

	// Handshake.
	assign adv = !v_s2 || !out_stall;
	assign in_stall = v_s1 && !adv;
	assign accept = in_valid && !in_stall;

	// Request decode.
	always_comb begin
		cur_d.special = write_special;
		cur_d.idx = write_index;
		cur_d.data = write_value;
		cur_d.valid = write_enable &&
			(CNT_W'(write_index) < (write_special ? SPC_LIM : GEN_LIM));

		na = CNT_W'(read_index_a) + CNT_W'(1);
		if (na == GEN_WRAP) begin
			na = '0;
		end
		nb = CNT_W'(read_index_b) + CNT_W'(1);
		if (nb == GEN_WRAP) begin
			nb = '0;
		end

		bind_hit_d = 1'b0;
		bind_idx_d = '0;
		for (int s = BINDING_SLOTS - 1; s >= 0; s--) begin
			if (binding_q[s][BIND_VLD_BIT] &&
			    binding_q[s][BIND_SPC_LSB +: IDX_W] == special_index) begin
				bind_hit_d = 1'b1;
				bind_idx_d = binding_q[s][BIND_GEN_LSB +: IDX_W];
			end
		end

		gaddr_d[PORT_A] = read_index_a;
		gaddr_d[PORT_B] = read_index_b;
		gaddr_d[PORT_C] = read_index_c;
		gaddr_d[PORT_D] = read_index_d;
		gaddr_d[PORT_DEST] = dest_index;
		gaddr_d[PORT_PAIR_A] = na[IDX_W-1:0];
		gaddr_d[PORT_PAIR_B] = nb[IDX_W-1:0];
		gaddr_d[PORT_BIND] = bind_idx_d;

		gok_d[PORT_A] = CNT_W'(read_index_a) < GEN_LIM;
		gok_d[PORT_B] = CNT_W'(read_index_b) < GEN_LIM;
		gok_d[PORT_C] = CNT_W'(read_index_c) < GEN_LIM;
		gok_d[PORT_D] = CNT_W'(read_index_d) < GEN_LIM;
		gok_d[PORT_DEST] = CNT_W'(dest_index) < GEN_LIM;
		gok_d[PORT_PAIR_A] = pair_a && (na < GEN_LIM);
		gok_d[PORT_PAIR_B] = pair_b && (nb < GEN_LIM);
		gok_d[PORT_BIND] = bind_hit_d && (CNT_W'(bind_idx_d) < GEN_LIM);

		sok_d = !bind_hit_d && (CNT_W'(special_index) < SPC_LIM);
	end

	// Writes land in the arrays when their request is accepted.
	always_comb begin
		gen_wr.en = accept && cur_d.valid && !cur_d.special;
		gen_wr.addr = cur_d.idx;
		gen_wr.data = cur_d.data;
		spc_wr.en = accept && cur_d.valid && cur_d.special;
		spc_wr.addr = cur_d.idx;
		spc_wr.data = cur_d.data;
	end

	for (genvar g = 0; g < NUM_GPORTS; g++) begin : g_gen_copy
		rfb_mem #(
			.DEPTH(GEN_DEPTH)
		) u_gen_mem (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (gen_wr),
			.rd_en   (accept),
			.rd_addr (gaddr_d[g]),
			.rd_data (gdata[g])
		);
	end

	rfb_mem #(
		.DEPTH(SPC_DEPTH)
	) u_spc_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (spc_wr),
		.rd_en   (accept),
		.rd_addr (special_index),
		.rd_data (sdata)
	);

	// Stage one: request register alongside the array reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= cur_d;
			gaddr_s1 <= gaddr_d;
			gok_s1 <= gok_d;
			bind_hit_s1 <= bind_hit_d;
			saddr_s1 <= special_index;
			sok_s1 <= sok_d;
		end
	end

	// Bypass of the request's own write over the array data.
	always_comb begin
		for (int p = 0; p < NUM_GPORTS; p++) begin
			if (!gok_s1[p]) begin
				gval[p] = '0;
			end else if (cur_s1.valid && !cur_s1.special && cur_s1.idx == gaddr_s1[p]) begin
				gval[p] = cur_s1.data;
			end else begin
				gval[p] = gdata[p];
			end
		end

		if (bind_hit_s1) begin
			sval = gval[PORT_BIND];
		end else if (!sok_s1) begin
			sval = '0;
		end else if (cur_s1.valid && cur_s1.special && cur_s1.idx == saddr_s1) begin
			sval = cur_s1.data;
		end else begin
			sval = sdata;
		end

		for (int p = 0; p < PORT_BIND; p++) begin
			res_d[p] = gval[p];
		end
		res_d[RES_SPECIAL] = sval;
	end

	// Stage two: result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = v_s2;
	assign value_a = res_s2[PORT_A];
	assign value_b = res_s2[PORT_B];
	assign value_c = res_s2[PORT_C];
	assign value_d = res_s2[PORT_D];
	assign dest_value = res_s2[PORT_DEST];
	assign pair_value_a = res_s2[PORT_PAIR_A];
	assign pair_value_b = res_s2[PORT_PAIR_B];
	assign special_value = res_s2[RES_SPECIAL];

`ifndef SYNTHESIS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> v_s1)
		else $error("stage one lost a blocked request");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> v_s2)
		else $error("request left stage one without reaching the result register");

	a_wr_one_array: assert property (@(posedge clk) disable iff (!arst_n)
		!(gen_wr.en && spc_wr.en))
		else $error("one request wrote both arrays");

	a_wr_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_wr.en || spc_wr.en) |-> (accept && write_enable))
		else $error("array written without an accepted write request");

	a_bind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(bind_hit_s1 && sok_s1))
		else $error("special read both bound and direct");
`endif

endmodule
`default_nettype wire
